@@ rtl/core/dpelq_pkg.sv @@
// shared types, sizes and helpers for the dual priority error log queue
// no dependencies; imported by every module of the block

package dpelq_pkg;

   localparam int DEPTH = 128;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ID_W = 16;
   localparam int CODE_W = 8;
   localparam int WORD_W = 32;
   localparam int REQ_W = 2;

   // request codes; the fourth code is ignored
   typedef enum logic [REQ_W-1:0] {
      REQ_LOG   = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
      logic [PTR_W-1:0] nxt;
      if (idx == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

@@ rtl/core/dual_priority_error_log_queue.sv @@
// the result strobe is registered in the execute state that follows accept
// no new item is taken while busy; the head entry is read from its queue
// memory at the accept edge and written back (stamped) or pushed in the next
// busy is high only in the execute state after accept; results cannot be stalled
// reset (synchronous, active high) empties both queues and zeroes the id counter
// top level: controller and datapath; depends on dpelq_pkg

module dual_priority_error_log_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dpelq_pkg::REQ_W-1:0]   req_type,
   input  logic [dpelq_pkg::CODE_W-1:0]  req_err_type,
   input  logic [dpelq_pkg::CODE_W-1:0]  req_sub_type,
   input  logic                          req_fast_context,
   input  logic [dpelq_pkg::ID_W-1:0]    req_time_low,
   output logic                          rsp_valid,
   output logic [dpelq_pkg::WORD_W-1:0]  rsp_error_word,
   output logic                          rsp_dropped
);
   import dpelq_pkg::*;

   dp_cmd_type cmd;

   dpelq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   dpelq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_err_type     (req_err_type),
      .req_sub_type     (req_sub_type),
      .req_fast_context (req_fast_context),
      .req_time_low     (req_time_low),
      .rsp_valid        (rsp_valid),
      .rsp_error_word   (rsp_error_word),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

@@ rtl/core/dpelq_ctrl.sv @@
// controller for the error log queue: idle / execute sequencing
// depends on dpelq_pkg

module dpelq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output dpelq_pkg::dp_cmd_type cmd
);
   import dpelq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/dpelq_datapath.sv @@
// datapath: two ring queues in memories, id counter, response registers
// depends on dpelq_pkg

module dpelq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  dpelq_pkg::dp_cmd_type         cmd,
   input  logic [dpelq_pkg::REQ_W-1:0]   req_type,
   input  logic [dpelq_pkg::CODE_W-1:0]  req_err_type,
   input  logic [dpelq_pkg::CODE_W-1:0]  req_sub_type,
   input  logic                          req_fast_context,
   input  logic [dpelq_pkg::ID_W-1:0]    req_time_low,
   output logic                          rsp_valid,
   output logic [dpelq_pkg::WORD_W-1:0]  rsp_error_word,
   output logic                          rsp_dropped
);
   import dpelq_pkg::*;

   logic [WORD_W-1:0] fast_mem [DEPTH];
   logic [WORD_W-1:0] slow_mem [DEPTH];

   logic [REQ_W-1:0]  op_ff;
   logic [CODE_W-1:0] err_ff;
   logic [CODE_W-1:0] sub_ff;
   logic              fast_ff;
   logic [ID_W-1:0]   time_ff;
   logic [WORD_W-1:0] fast_rd_ff;
   logic [WORD_W-1:0] slow_rd_ff;

   logic [PTR_W-1:0] fast_head_ff, fast_head_in, fast_tail_ff, fast_tail_in;
   logic [PTR_W-1:0] slow_head_ff, slow_head_in, slow_tail_ff, slow_tail_in;
   logic [CNT_W-1:0] fast_count_ff, fast_count_in, slow_count_ff, slow_count_in;
   logic [ID_W-1:0]  seq_ff, seq_in;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_drop_ff, rsp_drop_in;

   logic              fast_we, slow_we;
   logic [PTR_W-1:0]  fast_waddr, slow_waddr;
   logic [WORD_W-1:0] wdata;
   logic [WORD_W-1:0] head_word;
   logic [ID_W-1:0]   seed;

   always_comb begin
      fast_head_in = fast_head_ff;
      fast_tail_in = fast_tail_ff;
      fast_count_in = fast_count_ff;
      slow_head_in = slow_head_ff;
      slow_tail_in = slow_tail_ff;
      slow_count_in = slow_count_ff;
      seq_in = seq_ff;
      fast_we = 1'b0;
      slow_we = 1'b0;
      fast_waddr = fast_tail_ff;
      slow_waddr = slow_tail_ff;
      wdata = {err_ff, sub_ff, seq_ff};
      rsp_word_in = '0;
      rsp_drop_in = 1'b0;
      head_word = (fast_count_ff != '0) ? fast_rd_ff : slow_rd_ff;
      seed = (seq_ff == '0) ? time_ff : seq_ff;
      if (cmd.execute) begin
         case (op_ff)
            REQ_LOG: begin
               // the id is taken before the room check
               if (seq_ff != '0) begin
                  seq_in = seq_ff + ID_W'(1);
               end
               if (fast_ff) begin
                  if (fast_count_ff != CNT_W'(DEPTH)) begin
                     fast_we = 1'b1;
                     fast_tail_in = ring_next(fast_tail_ff);
                     fast_count_in = fast_count_ff + CNT_W'(1);
                  end else begin
                     rsp_drop_in = 1'b1;
                  end
               end else begin
                  if (slow_count_ff != CNT_W'(DEPTH)) begin
                     slow_we = 1'b1;
                     slow_tail_in = ring_next(slow_tail_ff);
                     slow_count_in = slow_count_ff + CNT_W'(1);
                  end else begin
                     rsp_drop_in = 1'b1;
                  end
               end
            end
            REQ_READ: begin
               if ((fast_count_ff != '0) || (slow_count_ff != '0)) begin
                  rsp_word_in = head_word;
                  if (head_word[ID_W-1:0] == '0) begin
                     // stamp the head in place, seeding the counter if needed
                     wdata = {head_word[WORD_W-1:ID_W], seed};
                     rsp_word_in = wdata;
                     seq_in = (seed != '0) ? seed + ID_W'(1) : seed;
                     if (fast_count_ff != '0) begin
                        fast_we = 1'b1;
                        fast_waddr = fast_head_ff;
                     end else begin
                        slow_we = 1'b1;
                        slow_waddr = slow_head_ff;
                     end
                  end
               end
            end
            REQ_CLEAR: begin
               if (fast_count_ff != '0) begin
                  fast_head_in = ring_next(fast_head_ff);
                  fast_count_in = fast_count_ff - CNT_W'(1);
               end else if (slow_count_ff != '0) begin
                  slow_head_in = ring_next(slow_head_ff);
                  slow_count_in = slow_count_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // memories: one write and one registered read port each
   always_ff @(posedge clock) begin
      if (fast_we) begin
         fast_mem[fast_waddr] <= wdata;
      end
      if (cmd.capture) begin
         fast_rd_ff <= fast_mem[fast_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (slow_we) begin
         slow_mem[slow_waddr] <= wdata;
      end
      if (cmd.capture) begin
         slow_rd_ff <= slow_mem[slow_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_type;
         err_ff <= req_err_type;
         sub_ff <= req_sub_type;
         fast_ff <= req_fast_context;
         time_ff <= req_time_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_head_ff <= '0;
         fast_tail_ff <= '0;
         fast_count_ff <= '0;
         slow_head_ff <= '0;
         slow_tail_ff <= '0;
         slow_count_ff <= '0;
         seq_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_word_ff <= '0;
         rsp_drop_ff <= 1'b0;
      end else begin
         fast_head_ff <= fast_head_in;
         fast_tail_ff <= fast_tail_in;
         fast_count_ff <= fast_count_in;
         slow_head_ff <= slow_head_in;
         slow_tail_ff <= slow_tail_in;
         slow_count_ff <= slow_count_in;
         seq_ff <= seq_in;
         rsp_valid_ff <= cmd.execute;
         rsp_word_ff <= rsp_word_in;
         rsp_drop_ff <= rsp_drop_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_error_word = rsp_word_ff;
   assign rsp_dropped = rsp_drop_ff;

endmodule

@@ rtl/core/dpelq_checker.sv @@
// port-level checks for dual_priority_error_log_queue, bound to the top level
// depends on dpelq_pkg

module dpelq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [dpelq_pkg::WORD_W-1:0]  rsp_error_word,
   input logic                          rsp_dropped
);
   import dpelq_pkg::*;

   // every accepted item is followed by a result strobe
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("no result two cycles after accepted item");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // a dropped log never carries a word
   a_drop_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_dropped |-> (rsp_valid && (rsp_error_word == '0)))
      else $error("dropped flag with word or without strobe");

endmodule

bind dual_priority_error_log_queue dpelq_checker u_dpelq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_error_word (rsp_error_word),
   .rsp_dropped    (rsp_dropped)
);
